// File: sv/lph_pkg.sv
// shared types, field widths and codes of the linear probe hash set
package lph_pkg;

    localparam int CAPACITY_DEF  = 1024;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int REQ_W    = 2;
    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 10;
    localparam int COUNT_W  = 11;

    localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = COUNT_W'(768);

    // key bits folded into the home slot per cycle
    localparam int DIGIT_W = 4;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_PRESENT = 3'd1,
        ST_ABSENT  = 3'd2,
        ST_FULL    = 3'd3,
        ST_REMOVED = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_HASH   = 5'b00100,
        S_PROBE  = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

endpackage

// File: sv/lph_ram.sv
// generic single-write, single-read ram with registered read data
module lph_ram #(
    parameter int WIDTH = lph_pkg::KEY_WIDTH_DEF + 2,
    parameter int DEPTH = lph_pkg::CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/lph_mod.sv
// iterative key modulo capacity, one digit per cycle; low bits if a power of 2
module lph_mod #(
    parameter int CAPACITY  = lph_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = lph_pkg::KEY_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [KEY_WIDTH-1:0]        i_key,
    output logic                        o_done,
    output logic [$clog2(CAPACITY)-1:0] o_rem
);

    import lph_pkg::*;

    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int EXT_W   = (KEY_WIDTH > IDX_W) ? KEY_WIDTH : IDX_W;
    localparam int DIGITS  = (EXT_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W   = DIGITS * DIGIT_W;
    localparam int CNT_W   = $clog2(DIGITS + 1);
    localparam bit IS_POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
    localparam logic [IDX_W:0] CAP_V = (IDX_W + 1)'(CAPACITY);

    logic [PAD_W-1:0] key_pad;
    logic [PAD_W-1:0] r_shift;
    logic [IDX_W-1:0] r_rem;
    logic [IDX_W-1:0] n_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    assign key_pad = PAD_W'(i_key);

    // restoring reduction: shift in one key bit, subtract capacity once if over
    always_comb begin
        logic [IDX_W:0] t;
        n_rem = r_rem;
        t     = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            t = {n_rem, r_shift[PAD_W-1-i]};
            if (t >= CAP_V) begin
                t = t - CAP_V;
            end
            n_rem = t[IDX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (IS_POW2) begin
                    r_rem  <= key_pad[IDX_W-1:0];
                    r_done <= 1'b1;
                end else begin
                    r_shift <= key_pad;
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(DIGITS);
                    r_busy  <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem   <= n_rem;
                r_shift <= r_shift << DIGIT_W;
                r_cnt   <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// File: sv/linear_probe_hash_set.sv
// top level of the linear probe hash set: request sequencer, slot ram and result register
// home slot: low key bits for a power-of-two capacity, else reduced from the padded key digit by digit;
//   then a probe walk along the chain (all slots on a full wrap); a finish state loads the result
// throughput: one item at a time; one slot ram read per cycle bounds the probe walk
// clear all sweeps every slot of the slot ram and then gives its result
// after reset the same sweep runs over every slot, with no result, before the first item is taken
module linear_probe_hash_set #(
    parameter int CAPACITY  = lph_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = lph_pkg::KEY_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [lph_pkg::COUNT_W-1:0]  i_max_entries,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [lph_pkg::REQ_W-1:0]    i_req_type,
    input  logic [lph_pkg::KEY_IN_W-1:0] i_key,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [lph_pkg::STATUS_W-1:0] o_status,
    output logic                         o_present,
    output logic [lph_pkg::SLOT_W-1:0]   o_slot,
    output logic [lph_pkg::COUNT_W-1:0]  o_count
);

    import lph_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int WORD_W = KEY_WIDTH + 2;
    localparam logic [IDX_W:0]   CAP_CNT  = (IDX_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    t_state               r_state;
    t_state               n_state;
    t_req                 r_req;
    logic [KEY_WIDTH-1:0] r_key;
    logic [COUNT_W-1:0]   r_max;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic                 r_clr_reply;

    logic [IDX_W-1:0]     r_addr;
    logic [IDX_W-1:0]     r_eval_idx;
    logic [IDX_W:0]       r_issue_cnt;
    logic                 r_pend;
    logic                 r_hit;
    logic [IDX_W-1:0]     r_hit_idx;
    logic                 r_free_vld;
    logic [IDX_W-1:0]     r_free_idx;
    logic [IDX_W-1:0]     r_sweep;

    logic                 r_out_valid;
    t_status              r_status;
    logic                 r_present;
    logic [SLOT_W-1:0]    r_slot;
    logic [COUNT_W-1:0]   r_count_o;

    logic                 in_accept;
    logic                 mod_start;
    logic                 mod_done;
    logic [IDX_W-1:0]     mod_rem;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;

    logic                 q_occ;
    logic                 q_mark;
    logic [KEY_WIDTH-1:0] q_key;
    logic                 issue;
    logic                 out_free;
    logic                 at_limit;

    logic                 load_out;
    t_status              n_status;
    logic                 n_present;
    logic [IDX_W-1:0]     n_slot;

    assign in_accept = i_in_valid && (r_state == S_IDLE);
    assign mod_start = in_accept && (t_req'(i_req_type) != REQ_CLEAR);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign issue     = (r_issue_cnt != CAP_CNT);
    assign at_limit  = (CMP_W'(r_count) >= CMP_W'(r_max));

    assign q_occ  = ram_rdata[KEY_WIDTH+1];
    assign q_mark = ram_rdata[KEY_WIDTH];
    assign q_key  = ram_rdata[KEY_WIDTH-1:0];

    lph_mod #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mod_start),
        .i_key   (KEY_WIDTH'(i_key)),
        .o_done  (mod_done),
        .o_rem   (mod_rem)
    );

    lph_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    // result and table update of the finishing request, clear sweep writes and count reset on an accepted clear
    always_comb begin
        load_out  = 1'b0;
        n_status  = ST_ABSENT;
        n_present = 1'b0;
        n_slot    = '0;
        n_count   = r_count;
        ram_we    = 1'b0;
        ram_waddr = r_sweep;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (in_accept && t_req'(i_req_type) == REQ_CLEAR) begin
            n_count = '0;
        end else if (r_state == S_FINISH && out_free) begin
            load_out = 1'b1;
            case (r_req)
                REQ_INSERT: begin
                    if (r_hit) begin
                        n_status  = ST_PRESENT;
                        n_present = 1'b1;
                        n_slot    = r_hit_idx;
                    end else if (at_limit || !r_free_vld) begin
                        n_status = ST_FULL;
                    end else begin
                        ram_we    = 1'b1;
                        ram_waddr = r_free_idx;
                        ram_wdata = {1'b1, 1'b1, r_key};
                        n_count   = r_count + CNT_W'(1);
                        n_status  = ST_ADDED;
                        n_present = 1'b1;
                        n_slot    = r_free_idx;
                    end
                end
                REQ_LOOKUP: begin
                    if (r_hit) begin
                        n_status  = ST_PRESENT;
                        n_present = 1'b1;
                        n_slot    = r_hit_idx;
                    end
                end
                REQ_REMOVE: begin
                    if (r_hit) begin
                        // occupied drops, the probe mark stays as a tombstone
                        ram_we    = 1'b1;
                        ram_waddr = r_hit_idx;
                        ram_wdata = {1'b0, 1'b1, r_key};
                        if (r_count != '0) begin
                            n_count = r_count - CNT_W'(1);
                        end
                        n_status = ST_REMOVED;
                        n_slot   = r_hit_idx;
                    end
                end
                REQ_CLEAR: begin
                    n_status = ST_REMOVED;
                end
                default: begin
                    n_status = ST_ABSENT;
                end
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_sweep == LAST_IDX) begin
                    n_state = r_clr_reply ? S_FINISH : S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (t_req'(i_req_type) == REQ_CLEAR) ? S_CLEAR : S_HASH;
                end
            end
            S_HASH: begin
                if (mod_done) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (r_pend) begin
                    if (!q_mark || (q_occ && q_key == r_key)) begin
                        n_state = S_FINISH;
                    end
                end else if (!issue) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_clr_reply <= 1'b0;
            r_count     <= '0;
            r_max       <= MAX_ENTRIES_RST;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_max <= i_max_entries;
            end

            if (in_accept) begin
                r_req <= t_req'(i_req_type);
                r_key <= KEY_WIDTH'(i_key);
                if (t_req'(i_req_type) == REQ_CLEAR) begin
                    r_sweep     <= '0;
                    r_clr_reply <= 1'b1;
                end
            end

            if (r_state == S_CLEAR) begin
                r_sweep <= r_sweep + IDX_W'(1);
            end

            if (r_state == S_HASH && mod_done) begin
                r_addr      <= mod_rem;
                r_issue_cnt <= '0;
                r_pend      <= 1'b0;
                r_hit       <= 1'b0;
                r_free_vld  <= 1'b0;
            end

            // read one slot per cycle ahead of the compare on the returning word
            if (r_state == S_PROBE) begin
                r_pend <= issue;
                if (issue) begin
                    r_eval_idx  <= r_addr;
                    r_addr      <= (r_addr == LAST_IDX) ? '0 : r_addr + IDX_W'(1);
                    r_issue_cnt <= r_issue_cnt + (IDX_W + 1)'(1);
                end
                if (r_pend) begin
                    if (q_mark && q_occ && q_key == r_key) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_eval_idx;
                    end else if (!q_occ && !r_free_vld) begin
                        r_free_vld <= 1'b1;
                        r_free_idx <= r_eval_idx;
                    end
                end
            end

            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_status  <= n_status;
            r_present <= n_present;
            r_slot    <= SLOT_W'(n_slot);
            r_count_o <= COUNT_W'(n_count);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_present   = r_present;
    assign o_slot      = r_slot;
    assign o_count     = r_count_o;

    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_HASH || r_state == S_CLEAR))
        else $error("accepted item did not start hashing or clearing");

    a_no_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE || r_state == S_HASH) |-> !ram_we)
        else $error("slot ram written during a probe walk");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (CNT_W + 1)'(r_count) <= (CNT_W + 1)'(CAPACITY))
        else $error("entry count above capacity");

    a_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_FINISH)
        else $error("result shown without a finishing request");

    a_remove_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && r_req == REQ_REMOVE && r_hit) |-> r_count != '0)
        else $error("remove hit with an empty count");

endmodule
